// File: rtl/bpq_pkg.sv
// Shared types and constants for the buffer pool free and full queues.
// No dependencies; every other file of the block uses this package.
package bpq_pkg;

  // Fixed field widths of the command and response words
  localparam int ID_W      = 8;
  localparam int OP_W      = 4;
  localparam int INFO_W    = 64;
  localparam int LEVEL_W   = 5;
  localparam int NUM_W     = 5;
  localparam int DEF_MAX_BUFFERS = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_NUM_BUFFERS = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_GET_EMPTY    = 4'd0,
    OP_PUT_EMPTY    = 4'd1,
    OP_GET_FULL     = 4'd2,
    OP_PUT_FULL     = 4'd3,
    OP_SWITCH_FULL  = 4'd4,
    OP_SWITCH_EMPTY = 4'd5,
    OP_PEEK_FULL    = 4'd6,
    OP_SET_INFO     = 4'd7,
    OP_GET_INFO     = 4'd8
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Queue update for one operation
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } q_cmd_t;

endpackage

// File: rtl/bpq_if.sv
// Command and response channel interfaces of the buffer pool block.
// Depends on bpq_pkg for field widths.
interface bpq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [bpq_pkg::OP_W-1:0]    opcode;
  logic [bpq_pkg::ID_W-1:0]    buffer_id;
  logic                        held_valid;
  logic [bpq_pkg::INFO_W-1:0]  info_value;

  modport source (output valid, opcode, buffer_id, held_valid, info_value, input ready);
  modport sink   (input valid, opcode, buffer_id, held_valid, info_value, output ready);
endinterface

interface bpq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [bpq_pkg::ID_W-1:0]    result_id;
  logic                        id_valid;
  logic [bpq_pkg::INFO_W-1:0]  info_out;
  logic [bpq_pkg::LEVEL_W-1:0] full_level;
  logic [bpq_pkg::LEVEL_W-1:0] empty_level;

  modport source (output valid, status, result_id, id_valid, info_out, full_level,
                  empty_level, input ready);
  modport sink   (input valid, status, result_id, id_valid, info_out, full_level,
                  empty_level, output ready);
endinterface

// File: rtl/bpq_queue.sv
// Circular id queue held in a synchronous memory with head, tail and count.
// Depends on bpq_pkg (q_cmd_t, ID_W).
module bpq_queue #(
  parameter int MAX_BUFFERS = bpq_pkg::DEF_MAX_BUFFERS,
  parameter bit INIT_IDS    = 1'b0,
  localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1,
  localparam int CNT_W = $clog2(MAX_BUFFERS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     init,
  input  logic [CNT_W-1:0]         init_num,
  input  logic                     rd_en,
  input  bpq_pkg::q_cmd_t          cmd,
  output logic [bpq_pkg::ID_W-1:0] head_id,
  output logic [CNT_W-1:0]         count,
  output logic [CNT_W-1:0]         count_next
);
  import bpq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BUFFERS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BUFFERS);

  logic [IDX_W-1:0] mem [MAX_BUFFERS];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] init_tail;

  // Level after this cycle's update
  always_comb begin
    count_next = count;
    if (cmd.push && !cmd.pop) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop && !cmd.push) begin
      count_next = count - CNT_W'(1);
    end
  end

  // With INIT_IDS the tail after a reload sits at the pool size, wrapped; else at zero
  assign init_tail = (INIT_IDS && init_num != MAX_CNT) ? IDX_W'(init_num) : '0;

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= INIT_IDS ? MAX_CNT : '0;
    end else if (init) begin
      head  <= '0;
      tail  <= init_tail;
      count <= INIT_IDS ? init_num : '0;
    end else begin
      if (cmd.pop) begin
        head <= (head == LAST_IDX) ? '0 : head + IDX_W'(1);
      end
      if (cmd.push) begin
        tail <= (tail == LAST_IDX) ? '0 : tail + IDX_W'(1);
      end
      count <= count_next;
    end
  end

  // Write at tail; read at head into a registered output
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= IDX_W'(cmd.push_id);
    end
    if (rd_en) begin
      rd_q <= mem[head];
    end
  end

  generate
    if (INIT_IDS) begin : g_init_ids
      logic [MAX_BUFFERS-1:0] written;
      logic                   rd_written;
      logic [IDX_W-1:0]       rd_idx;

      // Track entries written since the last reload; others hold their own index
      always_ff @(posedge clk) begin
        if (rst || init) begin
          written <= '0;
        end else if (cmd.push) begin
          written[tail] <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (rd_en) begin
          rd_written <= written[head];
          rd_idx     <= head;
        end
      end

      assign head_id = ID_W'(rd_written ? rd_q : rd_idx);
    end else begin : g_plain
      assign head_id = ID_W'(rd_q);
    end
  endgenerate

endmodule

// File: rtl/bpq_info.sv
// Info word table: one 64-bit word per buffer id in a synchronous memory,
// with per-entry written bits so a reload reads back as zero. Depends on bpq_pkg.
module bpq_info #(
  parameter int MAX_BUFFERS = bpq_pkg::DEF_MAX_BUFFERS,
  localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       init,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_addr,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [bpq_pkg::INFO_W-1:0] wr_data,
  output logic [bpq_pkg::INFO_W-1:0] rd_data
);
  import bpq_pkg::*;

  logic [INFO_W-1:0]      mem [MAX_BUFFERS];
  logic [MAX_BUFFERS-1:0] written;
  logic [INFO_W-1:0]      rd_q;
  logic                   rd_written;

  // Mark written entries, drop all marks on reload
  always_ff @(posedge clk) begin
    if (rst || init) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

// File: rtl/bpq_cfg.sv
// APB register slave holding the pool size; a legal write triggers a reload.
// Depends on bpq_pkg for address and data widths.
module bpq_cfg #(
  parameter int MAX_BUFFERS = bpq_pkg::DEF_MAX_BUFFERS,
  localparam int CNT_W = $clog2(MAX_BUFFERS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bpq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bpq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [CNT_W-1:0]               num_buffers,
  output logic                           init,
  output logic [CNT_W-1:0]               init_num
);
  import bpq_pkg::*;

  logic [CNT_W-1:0] num_reg;
  logic [NUM_W-1:0] wr_val;
  logic             sel_num;

  assign pready  = 1'b1;
  assign sel_num = (paddr[CFG_ADDR_W-1] == REG_NUM_BUFFERS);
  assign wr_val  = pwdata[NUM_W-1:0];

  // Accept only sizes from one up to the pool capacity
  assign init = psel && penable && pwrite && sel_num && (wr_val != '0) &&
                (32'(wr_val) <= 32'(MAX_BUFFERS));
  assign init_num = CNT_W'(wr_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_reg <= CNT_W'(MAX_BUFFERS);
    end else if (init) begin
      num_reg <= init_num;
    end
  end

  assign num_buffers = num_reg;
  assign prdata      = sel_num ? CFG_DATA_W'(num_reg) : '0;

endmodule

// File: rtl/buffer_pool_free_and_full_queues_core.sv
// Buffer pool with an empty (free) id queue, a full (ready) id queue and
// a 64-bit info word per id. Depends on bpq_pkg, bpq_if, bpq_queue,
// bpq_info and bpq_cfg.
//
// Usage: commands arrive on the cmd channel (opcode, buffer_id, held_valid,
// info_value) and each yields exactly one response word on rsp (status,
// result_id, id_valid, info_out and both queue levels after the operation).
// A word moves when valid and ready are both high at a rising edge.
// The response is registered; a new command is taken only after the last
// one has written back. Taking a command reads the queue heads and the info
// word from their registered memories; the write-back state then decides
// and writes back. A finished response sits in the output register while the
// next command is taken; a stalled receiver holds the write-back stage.
// Reset (rst, synchronous): pool size 16 (MAX_BUFFERS), empty queue holds
// ids in order, full queue empty, all info words zero. Writing num_buffers
// over the APB port reloads the same way with the new size; no sweep is needed.
module buffer_pool_free_and_full_queues_core #(
  parameter int MAX_BUFFERS = bpq_pkg::DEF_MAX_BUFFERS
) (
  input  logic                           clk,
  input  logic                           rst,
  bpq_cmd_if.sink                        cmd,
  bpq_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bpq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bpq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bpq_pkg::*;

  localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W = $clog2(MAX_BUFFERS + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  num_cnt;
  logic              init;
  logic [CNT_W-1:0]  init_num;

  logic              accept;
  logic              go;

  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   bid_q;
  logic              held_q;
  logic [INFO_W-1:0] info_q;

  q_cmd_t            e_cmd, f_cmd;
  logic [ID_W-1:0]   e_head, f_head;
  logic [CNT_W-1:0]  e_cnt, f_cnt, e_cnt_next, f_cnt_next;
  logic [INFO_W-1:0] info_rd;
  logic              info_wr;

  logic              e_nonempty, f_nonempty, e_room, f_room, bid_ok;
  logic              fail;
  logic [ID_W-1:0]   rid;
  logic              rvalid;
  logic [INFO_W-1:0] iout;

  bpq_cfg #(.MAX_BUFFERS(MAX_BUFFERS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .num_buffers(num_cnt), .init, .init_num
  );

  bpq_queue #(.MAX_BUFFERS(MAX_BUFFERS), .INIT_IDS(1'b1)) u_empty_q (
    .clk, .rst, .init, .init_num, .rd_en(accept), .cmd(e_cmd),
    .head_id(e_head), .count(e_cnt), .count_next(e_cnt_next)
  );

  bpq_queue #(.MAX_BUFFERS(MAX_BUFFERS), .INIT_IDS(1'b0)) u_full_q (
    .clk, .rst, .init, .init_num, .rd_en(accept), .cmd(f_cmd),
    .head_id(f_head), .count(f_cnt), .count_next(f_cnt_next)
  );

  bpq_info #(.MAX_BUFFERS(MAX_BUFFERS)) u_info (
    .clk, .rst, .init, .rd_en(accept), .rd_addr(IDX_W'(cmd.buffer_id)),
    .wr_en(info_wr), .wr_addr(IDX_W'(bid_q)), .wr_data(info_q), .rd_data(info_rd)
  );

  // Handshake: take a command only between operations
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign go        = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the command word for the write-back cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= cmd.opcode;
      bid_q  <= cmd.buffer_id;
      held_q <= cmd.held_valid;
      info_q <= cmd.info_value;
    end
  end

  assign e_nonempty = (e_cnt != '0);
  assign f_nonempty = (f_cnt != '0);
  assign e_room     = (e_cnt < num_cnt);
  assign f_room     = (f_cnt < num_cnt);
  assign bid_ok     = (32'(bid_q) < 32'(num_cnt));

  // Decide the operation and the queue updates
  always_comb begin
    fail    = 1'b0;
    rid     = '0;
    rvalid  = 1'b0;
    iout    = '0;
    info_wr = 1'b0;
    e_cmd   = '{push: 1'b0, pop: 1'b0, push_id: bid_q};
    f_cmd   = '{push: 1'b0, pop: 1'b0, push_id: bid_q};
    case (op_t'(op_q))
      OP_GET_EMPTY: begin
        if (e_nonempty) begin
          e_cmd.pop = go;
          rid       = e_head;
          rvalid    = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      OP_GET_FULL: begin
        if (f_nonempty) begin
          f_cmd.pop = go;
          rid       = f_head;
          rvalid    = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      OP_PUT_EMPTY: begin
        if (bid_ok && e_room) begin
          e_cmd.push = go;
        end else begin
          fail = 1'b1;
        end
      end
      OP_PUT_FULL: begin
        if (bid_ok && f_room) begin
          f_cmd.push = go;
        end else begin
          fail = 1'b1;
        end
      end
      OP_SWITCH_FULL: begin
        if (e_nonempty) begin
          e_cmd.pop  = go;
          f_cmd.push = go && held_q && bid_ok && f_room;
          rid        = e_head;
          rvalid     = 1'b1;
        end else begin
          fail   = 1'b1;
          rid    = held_q ? bid_q : '0;
          rvalid = held_q;
        end
      end
      OP_SWITCH_EMPTY: begin
        if (f_nonempty) begin
          f_cmd.pop  = go;
          e_cmd.push = go && held_q && bid_ok && e_room;
          rid        = f_head;
          rvalid     = 1'b1;
        end else begin
          fail   = 1'b1;
          rid    = held_q ? bid_q : '0;
          rvalid = held_q;
        end
      end
      OP_PEEK_FULL: begin
        if (f_nonempty) begin
          rid    = f_head;
          rvalid = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      OP_SET_INFO: begin
        if (bid_ok) begin
          info_wr = go;
        end else begin
          fail = 1'b1;
        end
      end
      OP_GET_INFO: begin
        if (bid_ok) begin
          iout = info_rd;
        end else begin
          fail = 1'b1;
        end
      end
      default: fail = 1'b1;
    endcase
  end

  // Output register: load on write-back, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.status      <= fail;
      rsp.result_id   <= rid;
      rsp.id_valid    <= rvalid;
      rsp.info_out    <= iout;
      rsp.full_level  <= LEVEL_W'(f_cnt_next);
      rsp.empty_level <= LEVEL_W'(e_cnt_next);
    end
  end

`ifndef SYNTHESIS
  a_empty_bound: assert property (@(posedge clk) disable iff (rst)
    e_cnt <= num_cnt) else $error("empty queue level above pool size");

  a_full_bound: assert property (@(posedge clk) disable iff (rst)
    f_cnt <= num_cnt) else $error("full queue level above pool size");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_EXEC)
    else $error("response loaded outside write-back");

  a_reload: assert property (@(posedge clk) disable iff (rst)
    init |=> (e_cnt == $past(init_num)) && (f_cnt == '0))
    else $error("reload left wrong queue levels");
`endif

endmodule

// File: tb/sv/tb_buffer_pool_free_and_full_queues_core.sv
// Testbench for buffer_pool_free_and_full_queues_core: random and directed commands, with
// every response word checked against a cycle-free model of both id queues and the info table.
// Depends on bpq_pkg, bpq_if and the core; the pool size is written through the APB port.
module tb_buffer_pool_free_and_full_queues_core;
  import bpq_pkg::*;

  localparam int FREE_Q = 0;
  localparam int READY_Q = 1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_NUM_BUFFERS = CFG_ADDR_W'(4 * REG_NUM_BUFFERS);
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   buffer_id;
    logic              held_valid;
    logic [INFO_W-1:0] info_value;
  } pool_cmd_t;

  typedef struct packed {
    logic               status;
    logic [ID_W-1:0]    result_id;
    logic               id_valid;
    logic [INFO_W-1:0]  info_out;
    logic [LEVEL_W-1:0] full_level;
    logic [LEVEL_W-1:0] empty_level;
  } pool_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  bpq_cmd_if cmd_ch ();
  bpq_rsp_if rsp_ch ();

  buffer_pool_free_and_full_queues_core DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Pool model: one array of id slots per queue, with head, tail and level
  logic [3:0]         slot_ids [2][DEF_MAX_BUFFERS];
  logic [3:0]         q_head [2];
  logic [3:0]         q_tail [2];
  logic [LEVEL_W-1:0] q_level [2];
  logic [INFO_W-1:0]  info_words [DEF_MAX_BUFFERS];
  logic [NUM_W-1:0]   pool_size;

  pool_cmd_t   cmd_backlog[$];
  pool_reply_t awaited_replies[$];
  pool_cmd_t   offered_cmd;
  int          mismatches = 0;
  bit          steady = 1'b0;
  bit          hold_rsp = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          stall_cycles = 0;

  // Refill the free queue with ids 0..n-1, empty the ready queue, clear info
  function automatic void reload_pool(logic [NUM_W-1:0] n);
    pool_size = n;
    for (int q = 0; q < 2; q++) begin
      q_head[q] = '0;
      q_tail[q] = '0;
      q_level[q] = '0;
      for (int i = 0; i < DEF_MAX_BUFFERS; i++) slot_ids[q][i] = '0;
    end
    for (int i = 0; i < DEF_MAX_BUFFERS; i++) info_words[i] = '0;
    for (int i = 0; i < n; i++) slot_ids[FREE_Q][i] = 4'(i);
    q_tail[FREE_Q] = n[3:0];
    q_level[FREE_Q] = n;
  endfunction

  function automatic bit take_id(int q, output logic [3:0] id);
    id = '0;
    if (q_level[q] == 0) return 1'b0;
    id = slot_ids[q][q_head[q]];
    q_head[q]++;
    q_level[q]--;
    return 1'b1;
  endfunction

  // Range-checked push; refuse when the queue already holds pool_size ids
  function automatic bit give_id(int q, logic [ID_W-1:0] id);
    if (id >= pool_size || q_level[q] >= pool_size) return 1'b0;
    slot_ids[q][q_tail[q]] = id[3:0];
    q_tail[q]++;
    q_level[q]++;
    return 1'b1;
  endfunction

  function automatic pool_reply_t predict_reply(pool_cmd_t c);
    pool_reply_t r;
    logic [3:0]  got;
    int          src;
    r = '0;
    case (c.opcode) inside
      OP_GET_EMPTY, OP_GET_FULL: begin
        src = (c.opcode == OP_GET_EMPTY) ? FREE_Q : READY_Q;
        if (take_id(src, got)) begin
          r.result_id = ID_W'(got);
          r.id_valid = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_PUT_EMPTY: r.status = !give_id(FREE_Q, c.buffer_id);
      OP_PUT_FULL: r.status = !give_id(READY_Q, c.buffer_id);
      OP_SWITCH_FULL, OP_SWITCH_EMPTY: begin
        src = (c.opcode == OP_SWITCH_FULL) ? FREE_Q : READY_Q;
        if (take_id(src, got)) begin
          // a held id that does not fit is dropped without a trace
          if (c.held_valid) void'(give_id(1 - src, c.buffer_id));
          r.result_id = ID_W'(got);
          r.id_valid = 1'b1;
        end else begin
          r.status = 1'b1;
          if (c.held_valid) begin
            r.result_id = c.buffer_id;
            r.id_valid = 1'b1;
          end
        end
      end
      OP_PEEK_FULL: begin
        if (q_level[READY_Q] != 0) begin
          r.result_id = ID_W'(slot_ids[READY_Q][q_head[READY_Q]]);
          r.id_valid = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_SET_INFO: begin
        if (c.buffer_id < pool_size) info_words[c.buffer_id[3:0]] = c.info_value;
        else r.status = 1'b1;
      end
      OP_GET_INFO: begin
        if (c.buffer_id < pool_size) r.info_out = info_words[c.buffer_id[3:0]];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.full_level = q_level[READY_Q];
    r.empty_level = q_level[FREE_Q];
    return r;
  endfunction

  function automatic void add_cmd(op_t op, int id, bit held, logic [INFO_W-1:0] info);
    pool_cmd_t c;
    c.opcode = op;
    c.buffer_id = ID_W'(id);
    c.held_valid = held;
    c.info_value = info;
    cmd_backlog.push_back(c);
  endfunction

  // Mostly in-range ids over all operations, some boundary ids, noise and bad opcodes
  function automatic void add_random_cmds(int count);
    pool_cmd_t c;
    int        pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) c.opcode = OP_W'($urandom_range(9, 15));
      else c.opcode = OP_W'($urandom_range(0, 8));
      pick = $urandom_range(0, 99);
      if (pick < 70) c.buffer_id = ID_W'($urandom_range(0, pool_size - 1));
      else if (pick < 80) c.buffer_id = ID_W'(pool_size);
      else c.buffer_id = ID_W'($urandom_range(0, 255));
      c.held_valid = $urandom_range(0, 1);
      c.info_value = {$urandom, $urandom};
      cmd_backlog.push_back(c);
    end
  endfunction

  // Wait until every command is taken and every response has come back
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access cycle; a legal size reloads the pool, others are ignored
  task automatic write_pool_size(logic [NUM_W-1:0] n);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_NUM_BUFFERS;
    pwdata <= CFG_DATA_W'(n);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (n != 0 && n <= DEF_MAX_BUFFERS) reload_pool(n);
  endtask

  // Driver: predict on each accepted word, then offer the next or idle
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) awaited_replies.push_back(predict_reply(offered_cmd));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
          offered_cmd = cmd_backlog.pop_front();
          cmd_ch.opcode <= offered_cmd.opcode;
          cmd_ch.buffer_id <= offered_cmd.buffer_id;
          cmd_ch.held_valid <= offered_cmd.held_valid;
          cmd_ch.info_value <= offered_cmd.info_value;
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold to fill the block
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_rsp && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || $urandom_range(0, 99) >= 20;
    end
  end

  // Monitor: compare each response word with the oldest prediction
  always @(posedge clk) begin
    pool_reply_t want;
    pool_reply_t seen;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen = {rsp_ch.status, rsp_ch.result_id, rsp_ch.id_valid, rsp_ch.info_out,
              rsp_ch.full_level, rsp_ch.empty_level};
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response with none expected: st=%0b id=%0d v=%0b info=%h full=%0d free=%0d",
                   $time, seen.status, seen.result_id, seen.id_valid, seen.info_out,
                   seen.full_level, seen.empty_level);
      end else begin
        want = awaited_replies.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch expected st=%0b id=%0d v=%0b info=%h full=%0d free=%0d",
                     $time, want.status, want.result_id, want.id_valid, want.info_out,
                     want.full_level, want.empty_level);
            $display("%0t:          actual   st=%0b id=%0d v=%0b info=%h full=%0d free=%0d",
                     $time, seen.status, seen.result_id, seen.id_valid, seen.info_out,
                     seen.full_level, seen.empty_level);
          end
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no word moving either way
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = '0;
    cmd_ch.buffer_id = '0;
    cmd_ch.held_valid = 1'b0;
    cmd_ch.info_value = '0;
    rsp_ch.ready = 1'b0;
    reload_pool(NUM_W'(DEF_MAX_BUFFERS));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: info bounds, empty and full queues, switch corners, bad opcodes
    add_cmd(OP_GET_INFO, 0, 1'b0, '0);
    add_cmd(OP_SET_INFO, 15, 1'b0, '1);
    add_cmd(OP_GET_INFO, 15, 1'b0, '0);
    add_cmd(OP_SET_INFO, 16, 1'b1, '1);
    add_cmd(OP_GET_INFO, 255, 1'b1, '0);
    add_cmd(OP_GET_FULL, 0, 1'b0, '0);
    add_cmd(OP_PEEK_FULL, 0, 1'b0, '0);
    add_cmd(OP_SWITCH_EMPTY, 200, 1'b1, '0);
    add_cmd(OP_SWITCH_EMPTY, 7, 1'b0, '0);
    add_cmd(OP_PUT_EMPTY, 3, 1'b0, '0);
    add_cmd(OP_PUT_FULL, 16, 1'b0, '0);
    add_cmd(OP_GET_EMPTY, 0, 1'b0, '0);
    add_cmd(OP_GET_EMPTY, 0, 1'b0, '0);
    add_cmd(OP_PUT_FULL, 0, 1'b0, '0);
    add_cmd(OP_PEEK_FULL, 0, 1'b0, '0);
    add_cmd(OP_SWITCH_FULL, 1, 1'b1, '0);
    add_cmd(OP_SWITCH_FULL, 77, 1'b1, '0);
    add_cmd(OP_SWITCH_EMPTY, 2, 1'b1, '0);
    add_cmd(OP_GET_FULL, 0, 1'b0, '0);
    add_cmd(OP_PUT_EMPTY, 255, 1'b0, '0);
    add_cmd(op_t'(OP_W'(9)), 0, 1'b0, '0);
    add_cmd(op_t'(OP_W'(15)), 255, 1'b1, '1);
    add_cmd(OP_PUT_EMPTY, 0, 1'b0, '0);
    add_random_cmds(300);
    wait_idle();

    // Smallest pool: both queues hit empty and full all the time
    write_pool_size(NUM_W'(1));
    add_random_cmds(150);
    wait_idle();

    // Illegal sizes must leave the pool untouched
    write_pool_size(NUM_W'(0));
    add_random_cmds(50);
    wait_idle();
    write_pool_size(NUM_W'(31));
    add_random_cmds(50);
    wait_idle();

    // Back-to-back words with no idling on either side
    write_pool_size(NUM_W'(5));
    steady = 1'b1;
    add_random_cmds(250);
    wait_idle();
    steady = 1'b0;

    // Largest pool with a long receiver hold so the command side stalls
    write_pool_size(NUM_W'(DEF_MAX_BUFFERS));
    hold_rsp = 1'b1;
    add_random_cmds(250);
    wait_idle();

    write_pool_size(NUM_W'(9));
    add_random_cmds(200);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bpq_pkg.sv
rtl/bpq_if.sv
rtl/bpq_queue.sv
rtl/bpq_info.sv
rtl/bpq_cfg.sv
rtl/buffer_pool_free_and_full_queues_core.sv
tb/sv/tb_buffer_pool_free_and_full_queues_core.sv
